// ===== hw/rtl/sfs_pkg.sv =====
package sfs_pkg;

  localparam int COORD_W = 12;
  localparam int DIST_W  = 11;
  localparam int TGT_W   = 7;
  localparam int FCNT_W  = 7;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int SUM_W   = SQ_W + 1;
  localparam int LIM_W   = 2 * DIST_W;

  localparam logic [DIST_W-1:0] DIST_MAX    = '1;
  localparam int                MIN_SPACING = 3;
  localparam logic [TGT_W-1:0]  TARGET_RST  = TGT_W'(8);

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_RUN  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LIM,
    ST_CRD,
    ST_CCHK,
    ST_FRD,
    ST_FDIFF,
    ST_SQX,
    ST_SQY,
    ST_FCMP,
    ST_KEEP,
    ST_NEXT,
    ST_PEND,
    ST_ERD,
    ST_ELD
  } sfs_state_t;

  typedef struct packed {
    logic load;
    logic run_start;
    logic lim_calc;
    logic cand_rd;
    logic j_clr;
    logic feat_rd;
    logic diff;
    logic sq_x;
    logic sq_y;
    logic j_inc;
    logic keep;
    logic scan_inc;
    logic scan_clr;
    logic grow;
    logic shrink;
    logic run_end;
    logic emit_ld;
  } sfs_cmd_t;

  typedef struct packed {
    logic cand_empty;
    logic fc_zero;
    logic j_last;
    logic dist_ok;
    logic scan_last;
    logic num_ok;
    logic first;
    logic d_at_max;
    logic d_le_min;
    logic out_free;
  } sfs_sts_t;

endpackage

// ===== hw/rtl/sfs_in_if.sv =====
interface sfs_in_if import sfs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               mode;
  logic [COORD_W-1:0] cand_x;
  logic [COORD_W-1:0] cand_y;
  logic [DIST_W-1:0]  start_distance;

  modport source (output valid, mode, cand_x, cand_y, start_distance, input ready);
  modport sink (input valid, mode, cand_x, cand_y, start_distance, output ready);
endinterface

// ===== hw/rtl/sfs_out_if.sv =====
interface sfs_out_if import sfs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] feat_x;
  logic [COORD_W-1:0] feat_y;
  logic               valid_res;
  logic               last;
  logic               overflow;

  modport source (output valid, feat_x, feat_y, valid_res, last, overflow, input ready);
  modport sink (input valid, feat_x, feat_y, valid_res, last, overflow, output ready);
endinterface

// ===== hw/rtl/sfs_cfg_if.sv =====
interface sfs_cfg_if import sfs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [TGT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== hw/rtl/sfs_ram.sv =====
module sfs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/sfs_ctrl.sv =====
module sfs_ctrl import sfs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_mode,
  input  sfs_sts_t sts,
  output logic     in_ready,
  output sfs_cmd_t cmd
);

  sfs_state_t state_r, state_nxt;
  logic       emit_last;

  assign emit_last = sts.fc_zero || sts.j_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_mode == MODE_RUN) begin
          state_nxt = sts.cand_empty ? ST_ELD : ST_LIM;
        end
      end
      ST_LIM:   state_nxt = ST_CRD;
      ST_CRD:   state_nxt = ST_CCHK;
      ST_CCHK:  state_nxt = sts.fc_zero ? ST_KEEP : ST_FRD;
      ST_FRD:   state_nxt = ST_FDIFF;
      ST_FDIFF: state_nxt = ST_SQX;
      ST_SQX:   state_nxt = ST_SQY;
      ST_SQY:   state_nxt = ST_FCMP;
      ST_FCMP: begin
        if (!sts.dist_ok) begin
          state_nxt = ST_NEXT;
        end else begin
          state_nxt = sts.j_last ? ST_KEEP : ST_FRD;
        end
      end
      ST_KEEP:  state_nxt = ST_NEXT;
      ST_NEXT:  state_nxt = sts.scan_last ? ST_PEND : ST_CRD;
      ST_PEND: begin
        if (sts.first && sts.num_ok && !sts.d_at_max) begin
          state_nxt = ST_LIM;
        end else if (sts.num_ok || sts.d_le_min) begin
          state_nxt = sts.fc_zero ? ST_ELD : ST_ERD;
        end else begin
          state_nxt = ST_LIM;
        end
      end
      ST_ERD:   state_nxt = ST_ELD;
      ST_ELD: begin
        if (sts.out_free) begin
          state_nxt = emit_last ? ST_IDLE : ST_ERD;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load      = (in_mode == MODE_LOAD);
          cmd.run_start = (in_mode == MODE_RUN);
        end
      end
      ST_LIM:   cmd.lim_calc = 1'b1;
      ST_CRD: begin
        cmd.cand_rd = 1'b1;
        cmd.j_clr   = 1'b1;
      end
      ST_FRD:   cmd.feat_rd = 1'b1;
      ST_FDIFF: cmd.diff = 1'b1;
      ST_SQX:   cmd.sq_x = 1'b1;
      ST_SQY:   cmd.sq_y = 1'b1;
      ST_FCMP:  cmd.j_inc = sts.dist_ok && !sts.j_last;
      ST_KEEP:  cmd.keep = 1'b1;
      ST_NEXT:  cmd.scan_inc = !sts.scan_last;
      ST_PEND: begin
        cmd.scan_clr = 1'b1;
        if (sts.first && sts.num_ok && !sts.d_at_max) begin
          cmd.grow = 1'b1;
        end else begin
          cmd.shrink  = 1'b1;
          cmd.run_end = sts.num_ok || sts.d_le_min;
        end
      end
      ST_ERD:   cmd.feat_rd = 1'b1;
      ST_ELD: begin
        if (sts.out_free) begin
          cmd.emit_ld = 1'b1;
          cmd.j_inc   = !emit_last;
        end
      end
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/sfs_dp.sv =====
module sfs_dp import sfs_pkg::*; #(
  parameter int MAX_CANDIDATES = 1024,
  parameter int MAX_FEATURES   = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sfs_cmd_t           cmd,
  output sfs_sts_t           sts,
  input  logic [COORD_W-1:0] cand_x,
  input  logic [COORD_W-1:0] cand_y,
  input  logic [DIST_W-1:0]  start_distance,
  input  logic               cfg_wr,
  input  logic [TGT_W-1:0]   cfg_data,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [COORD_W-1:0] feat_x,
  output logic [COORD_W-1:0] feat_y,
  output logic               valid_res,
  output logic               last,
  output logic               overflow
);

  localparam int CCNT_W = $clog2(MAX_CANDIDATES + 1);
  localparam int CIDX_W = $clog2(MAX_CANDIDATES);
  localparam int FIDX_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;

  logic [TGT_W-1:0]   target_r;
  logic [CCNT_W-1:0]  cand_cnt_r;
  logic [CIDX_W-1:0]  scan_r;
  logic [FIDX_W-1:0]  j_r;
  logic [FCNT_W-1:0]  fc_r;
  logic [DIST_W-1:0]  d_r;
  logic               first_r;
  logic               ovf_r;
  logic               out_valid_r;

  logic [LIM_W-1:0]   lim_r;
  logic [COORD_W-1:0] dx_r;
  logic [COORD_W-1:0] dy_r;
  logic [SQ_W-1:0]    dx2_r;
  logic [SQ_W-1:0]    dy2_r;
  logic [COORD_W-1:0] out_x_r;
  logic [COORD_W-1:0] out_y_r;
  logic               out_vres_r;
  logic               out_last_r;
  logic               out_ovf_r;

  logic [2*COORD_W-1:0] cand_rd_data;
  logic [2*COORD_W-1:0] feat_rd_data;
  logic [COORD_W-1:0]   cx, cy, fx, fy;
  logic                 cand_full;
  logic                 feat_room;
  logic                 feat_wr;
  logic [COORD_W-1:0]   sq_op;
  logic [SQ_W-1:0]      sq_prod;
  logic [SUM_W-1:0]     dist_sum;

  assign cx = cand_rd_data[2*COORD_W-1:COORD_W];
  assign cy = cand_rd_data[COORD_W-1:0];
  assign fx = feat_rd_data[2*COORD_W-1:COORD_W];
  assign fy = feat_rd_data[COORD_W-1:0];

  assign cand_full = (cand_cnt_r == CCNT_W'(MAX_CANDIDATES));
  assign feat_room = (fc_r < FCNT_W'(MAX_FEATURES));
  assign feat_wr   = cmd.keep && feat_room;

  sfs_ram #(
    .WIDTH (2 * COORD_W),
    .DEPTH (MAX_CANDIDATES)
  ) u_cand_ram (
    .clk     (clk),
    .wr_en   (cmd.load && !cand_full),
    .wr_addr (cand_cnt_r[CIDX_W-1:0]),
    .wr_data ({cand_x, cand_y}),
    .rd_en   (cmd.cand_rd),
    .rd_addr (scan_r),
    .rd_data (cand_rd_data)
  );

  sfs_ram #(
    .WIDTH (2 * COORD_W),
    .DEPTH (MAX_FEATURES)
  ) u_feat_ram (
    .clk     (clk),
    .wr_en   (feat_wr),
    .wr_addr (fc_r[FIDX_W-1:0]),
    .wr_data (cand_rd_data),
    .rd_en   (cmd.feat_rd),
    .rd_addr (j_r),
    .rd_data (feat_rd_data)
  );

  // one squarer shared by the spacing limit and both distance terms
  always_comb begin
    if (cmd.lim_calc) begin
      sq_op = COORD_W'(d_r);
    end else if (cmd.sq_x) begin
      sq_op = dx_r;
    end else begin
      sq_op = dy_r;
    end
  end

  assign sq_prod  = sq_op * sq_op;
  assign dist_sum = SUM_W'(dx2_r) + SUM_W'(dy2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= TARGET_RST;
      cand_cnt_r  <= '0;
      scan_r      <= '0;
      j_r         <= '0;
      fc_r        <= '0;
      d_r         <= '0;
      first_r     <= 1'b1;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        target_r <= cfg_data;
      end

      if (cmd.load && !cand_full) begin
        cand_cnt_r <= cand_cnt_r + CCNT_W'(1);
      end else if (cmd.run_end) begin
        cand_cnt_r <= '0;
      end

      if (cmd.scan_clr || cmd.run_end) begin
        scan_r <= '0;
      end else if (cmd.scan_inc) begin
        scan_r <= scan_r + CIDX_W'(1);
      end

      if (cmd.j_clr || cmd.run_end) begin
        j_r <= '0;
      end else if (cmd.j_inc) begin
        j_r <= j_r + FIDX_W'(1);
      end

      if (cmd.run_start) begin
        d_r     <= start_distance;
        fc_r    <= '0;
        first_r <= 1'b1;
        ovf_r   <= 1'b0;
      end else begin
        if (feat_wr) begin
          fc_r <= fc_r + FCNT_W'(1);
        end else if (cmd.grow) begin
          fc_r <= '0;
        end
        if (cmd.keep && !feat_room) begin
          ovf_r <= 1'b1;
        end
        if (cmd.grow) begin
          d_r <= d_r + DIST_W'(1);
        end else if (cmd.shrink) begin
          d_r     <= d_r - DIST_W'(1);
          first_r <= 1'b0;
        end
      end

      if (cmd.emit_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lim_calc) begin
      lim_r <= sq_prod[LIM_W-1:0];
    end
    if (cmd.diff) begin
      dx_r <= (cx > fx) ? (cx - fx) : (fx - cx);
      dy_r <= (cy > fy) ? (cy - fy) : (fy - cy);
    end
    if (cmd.sq_x) begin
      dx2_r <= sq_prod;
    end
    if (cmd.sq_y) begin
      dy2_r <= sq_prod;
    end
    if (cmd.emit_ld) begin
      out_x_r    <= sts.fc_zero ? '0 : fx;
      out_y_r    <= sts.fc_zero ? '0 : fy;
      out_vres_r <= !sts.fc_zero;
      out_last_r <= sts.fc_zero || sts.j_last;
      out_ovf_r  <= ovf_r;
    end
  end

  always_comb begin
    sts.cand_empty = (cand_cnt_r == '0);
    sts.fc_zero    = (fc_r == '0);
    sts.j_last     = ((FCNT_W'(j_r) + FCNT_W'(1)) == fc_r);
    sts.dist_ok    = (dist_sum >= SUM_W'(lim_r));
    sts.scan_last  = ((CCNT_W'(scan_r) + CCNT_W'(1)) == cand_cnt_r);
    sts.num_ok     = (fc_r >= target_r);
    sts.first      = first_r;
    sts.d_at_max   = (d_r == DIST_MAX);
    // the decrement ends below the floor
    sts.d_le_min   = (d_r <= DIST_W'(MIN_SPACING));
    sts.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign feat_x    = out_x_r;
  assign feat_y    = out_y_r;
  assign valid_res = out_vres_r;
  assign last      = out_last_r;
  assign overflow  = out_ovf_r;

endmodule

// ===== hw/rtl/scattered_feature_selection_core.sv =====
// Greedy minimum-distance feature selection. Send candidate points best first as
// items with mode 0 (one cycle each; points beyond MAX_CANDIDATES are dropped), then
// one item with mode 1 carrying the start spacing. The run scans the candidate RAM
// once per pass and compares each candidate against the kept points one at a time
// through a single shared squarer, stopping at the first one too close; each test
// reads the point, takes the differences, squares x and y and compares. While the
// first phase still meets target_count the spacing grows by one per pass with the
// kept list cleared; afterwards it shrinks by one per pass with the list growing,
// until the target is met or the spacing drops below 3. Kept points then leave in
// keep order, each read and loaded when the sink is free, last marking the final
// one and overflow set on every result if the feature RAM overflowed. An empty
// store or an empty selection gives one result with valid_res low and last high.
// The candidate count clears at the end of every run. Write target_count on the
// cfg channel only while no run is in progress; it resets to 8.
module scattered_feature_selection_core import sfs_pkg::*; #(
  parameter int MAX_CANDIDATES = 1024,
  parameter int MAX_FEATURES   = 64
) (
  input logic       clk,
  input logic       rst_n,
  sfs_in_if.sink    in_ch,
  sfs_out_if.source out_ch,
  sfs_cfg_if.sink   cfg_ch
);

  sfs_cmd_t cmd;
  sfs_sts_t sts;
  logic     in_ready;

  // the target register takes writes at any time
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;

  sfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_mode  (in_ch.mode),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  sfs_dp #(
    .MAX_CANDIDATES (MAX_CANDIDATES),
    .MAX_FEATURES   (MAX_FEATURES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cand_x         (in_ch.cand_x),
    .cand_y         (in_ch.cand_y),
    .start_distance (in_ch.start_distance),
    .cfg_wr         (cfg_ch.valid),
    .cfg_data       (cfg_ch.data),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .feat_x         (out_ch.feat_x),
    .feat_y         (out_ch.feat_y),
    .valid_res      (out_ch.valid_res),
    .last           (out_ch.last),
    .overflow       (out_ch.overflow)
  );

endmodule

// ===== hw/rtl/sfs_checker.sv =====
module sfs_checker import sfs_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_mode,
  input logic out_valid,
  input logic out_ready,
  input logic out_valid_res,
  input logic out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode == MODE_LOAD |=> in_ready)
    else $error("load item stalled the input");

  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode == MODE_RUN |=> !in_ready)
    else $error("run item did not start a run");

  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input taken in the middle of emission");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> out_last)
    else $error("empty result not marked last");

endmodule

bind scattered_feature_selection_core sfs_checker u_sfs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_mode       (in_ch.mode),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_valid_res (out_ch.valid_res),
  .out_last      (out_ch.last)
);
